FILE: hdl/single_axis_vector_rotator_assert.svh
// assertion macros for the single axis vector rotator
// needs clk and rst_n in the scope of each use
`ifndef SINGLE_AXIS_VECTOR_ROTATOR_ASSERT_SVH
`define SINGLE_AXIS_VECTOR_ROTATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define SVR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("svr assertion failed");

`define SVR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svr assertion failed");

`else

`define SVR_ASSERT(lbl, prop)

`define SVR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/svr_pkg.sv
// shared types and constants of the single axis vector rotator
// no dependencies
`timescale 1ns / 1ps

package svr_pkg;

    localparam int GUARD_BITS = 8;
    localparam int TURN_BITS  = 32;
    localparam int TABLE_LEN  = 32;

    // inverse cordic gain, q0.32
    localparam logic [31:0] INV_GAIN = 32'd2608131496;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        MODE_X,
        MODE_Y,
        MODE_Z,
        MODE_NONE
    } svr_mode_t;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } svr_quad_t;

endpackage

FILE: hdl/svr_cordic_stage.sv
// one registered cordic micro-rotation with a fixed shift
// depends on svr_pkg for the arctangent table
`timescale 1ns / 1ps

module svr_cordic_stage #(
    parameter int W     = 43,
    parameter int SHIFT = 0
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [W-1:0]                  u_in,
    input  logic signed [W-1:0]                  v_in,
    input  logic signed [svr_pkg::TURN_BITS-1:0] z_in,
    output logic signed [W-1:0]                  u_reg,
    output logic signed [W-1:0]                  v_reg,
    output logic signed [svr_pkg::TURN_BITS-1:0] z_reg
);

    import svr_pkg::*;

    localparam logic signed [TURN_BITS-1:0] STEP = ATAN_TURNS[SHIFT];

    logic signed [W-1:0]         du;
    logic signed [W-1:0]         dv;
    logic signed [W-1:0]         u_next;
    logic signed [W-1:0]         v_next;
    logic signed [TURN_BITS-1:0] z_next;

    assign du = v_in >>> SHIFT;
    assign dv = u_in >>> SHIFT;

    always_comb
    begin
        if (!z_in[TURN_BITS-1])
        begin
            u_next = u_in - du;
            v_next = v_in + dv;
            z_next = z_in - STEP;
        end
        else
        begin
            u_next = u_in + du;
            v_next = v_in - dv;
            z_next = z_in + STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
            z_reg <= z_next;
        end
    end

endmodule

FILE: hdl/svr_gain.sv
// four-stage gain compensation, guard removal and saturation of one coordinate
// depends on svr_pkg for the gain constant and guard width
`timescale 1ns / 1ps

module svr_gain #(
    parameter int W          = 43,
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [W-1:0]          w_in,
    output logic signed [COORD_BITS-1:0] res_reg,
    output logic                         sat_reg
);

    import svr_pkg::*;

    localparam int MW = (W > 32) ? W : 33;
    localparam int HW = MW - 32;
    localparam int PW = HW + 33;
    localparam int RW = PW + 1 - GUARD_BITS;

    localparam logic [RW-1:0] LIM_POS = {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic [RW-1:0] LIM_NEG =
        {{(RW-COORD_BITS){1'b0}}, 1'b1, {(COORD_BITS-1){1'b0}}};

    logic          neg1_reg;
    logic          neg2_reg;
    logic          neg3_reg;
    logic [MW-1:0] mag_reg;
    logic [MW-1:0] mag_next;
    logic [HW+31:0] ph_reg;
    logic [31:0]   pl_reg;
    logic [PW-1:0] psum;
    logic [PW:0]   pround;
    logic [RW-1:0] r_reg;
    logic [COORD_BITS-1:0] r_low;
    logic signed [COORD_BITS-1:0] res_next;
    logic          sat_next;

    // magnitude
    assign mag_next = w_in[W-1] ? MW'(-w_in) : MW'(w_in);

    // floor(m * gain / 2^32) as two partial products
    assign psum    = PW'(ph_reg) + PW'(pl_reg);
    assign pround  = (PW+1)'(psum) + (PW+1)'(1 << (GUARD_BITS - 1));
    assign r_low   = r_reg[COORD_BITS-1:0];

    always_comb
    begin
        sat_next = 1'b0;
        if (!neg3_reg && (r_reg > LIM_POS))
        begin
            sat_next = 1'b1;
            res_next = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        else if (neg3_reg && (r_reg > LIM_NEG))
        begin
            sat_next = 1'b1;
            res_next = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else if (neg3_reg)
        begin
            res_next = signed'(~r_low + 1'b1);
        end
        else
        begin
            res_next = signed'(r_low);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= w_in[W-1];
            mag_reg  <= mag_next;
            neg2_reg <= neg1_reg;
            ph_reg   <= (HW+32)'(mag_reg[MW-1:32]) * (HW+32)'(INV_GAIN);
            pl_reg   <= 32'((64'(mag_reg[31:0]) * 64'(INV_GAIN)) >> 32);
            neg3_reg <= neg2_reg;
            r_reg    <= RW'(pround >> GUARD_BITS);
            res_reg  <= res_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

FILE: hdl/single_axis_vector_rotator.sv
// Single axis vector rotator: rotates a 3D point about the X, Y or Z axis by a
// fraction-of-a-turn angle using a fully pipelined CORDIC. One item is taken
// per clock cycle while in_ready is high, and each result passes through
// ITERATIONS + 5 register stages: one input stage with the quarter-turn
// pre-rotation, loaded at the accepting edge, one stage per micro-rotation and
// four gain and saturation stages. A one-entry output buffer takes one result
// while out_ready is low; the pipeline and in_ready then hold until that
// result is taken.
// left_handed negates the angle.
// depends on svr_pkg, svr_cordic_stage, svr_gain and the assertion macros
`timescale 1ns / 1ps

`include "single_axis_vector_rotator_assert.svh"

module single_axis_vector_rotator #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16,
    parameter int ITERATIONS = 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic                         cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic signed [COORD_BITS-1:0] x_in,
    input  logic signed [COORD_BITS-1:0] y_in,
    input  logic signed [COORD_BITS-1:0] z_in,
    input  logic [ANGLE_BITS-1:0]        angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] x_out,
    output logic signed [COORD_BITS-1:0] y_out,
    output logic signed [COORD_BITS-1:0] z_out,
    output logic                         saturated
);

    import svr_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int W     = C + GUARD_BITS + 3;
    localparam int EXT   = W - C - GUARD_BITS;
    localparam int DEPTH = ITERATIONS + 5;
    localparam int SW    = 2 + 3 * C;
    localparam int RES_W = 1 + 3 * C;

    logic left_handed_reg;
    logic advance;
    logic skid_full_reg;
    logic skid_full_next;
    logic [DEPTH-1:0] valid_reg;
    logic [SW-1:0]    side_reg [DEPTH];
    logic [RES_W-1:0] skid_reg;
    logic [RES_W-1:0] res_last;
    logic [RES_W-1:0] res_out;

    // input stage
    svr_mode_t                    mode_sel;
    svr_quad_t                    quad;
    logic signed [C-1:0]          u_c;
    logic signed [C-1:0]          v_c;
    logic signed [W-1:0]          u_w;
    logic signed [W-1:0]          v_w;
    logic signed [W-1:0]          u0_next;
    logic signed [W-1:0]          v0_next;
    logic [ANGLE_BITS-1:0]        a_eff;
    logic [TURN_BITS-1:0]         turn;

    logic signed [W-1:0]          u_pipe [ITERATIONS+1];
    logic signed [W-1:0]          v_pipe [ITERATIONS+1];
    logic signed [TURN_BITS-1:0]  z_pipe [ITERATIONS+1];

    logic signed [C-1:0] ru;
    logic signed [C-1:0] rv;
    logic                sat_u;
    logic                sat_v;
    svr_mode_t           mode_last;
    logic signed [C-1:0] xo;
    logic signed [C-1:0] yo;
    logic signed [C-1:0] zo;
    logic signed [C-1:0] xr;
    logic signed [C-1:0] yr;
    logic signed [C-1:0] zr;
    logic                sr;

    assign advance  = !skid_full_reg;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_handed_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            left_handed_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        mode_sel = svr_mode_t'(mode);
        unique case (mode_sel)
            MODE_X:
            begin
                u_c = y_in;
                v_c = z_in;
            end
            MODE_Y:
            begin
                u_c = z_in;
                v_c = x_in;
            end
            default:
            begin
                u_c = x_in;
                v_c = y_in;
            end
        endcase
        u_w   = {{EXT{u_c[C-1]}}, u_c, {GUARD_BITS{1'b0}}};
        v_w   = {{EXT{v_c[C-1]}}, v_c, {GUARD_BITS{1'b0}}};
        a_eff = left_handed_reg ? ANGLE_BITS'(~angle + 1'b1) : angle;
        turn  = {a_eff, {(TURN_BITS-ANGLE_BITS){1'b0}}};
        quad  = svr_quad_t'(turn[TURN_BITS-1 -: 2]);
        unique case (quad)
            QUAD_1:
            begin
                u0_next = -v_w;
                v0_next = u_w;
            end
            QUAD_2:
            begin
                u0_next = -u_w;
                v0_next = -v_w;
            end
            QUAD_3:
            begin
                u0_next = v_w;
                v0_next = -u_w;
            end
            default:
            begin
                u0_next = u_w;
                v0_next = v_w;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            u_pipe[0]   <= u0_next;
            v_pipe[0]   <= v0_next;
            z_pipe[0]   <= signed'({2'b00, turn[TURN_BITS-3:0]});
            side_reg[0] <= {mode, x_in, y_in, z_in};
        end
    end

    // valid bits and side data travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    for (genvar k = 1; k < DEPTH; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        svr_cordic_stage #(
            .W     (W),
            .SHIFT (i)
        ) u_stage (
            .clk   (clk),
            .en    (advance),
            .u_in  (u_pipe[i]),
            .v_in  (v_pipe[i]),
            .z_in  (z_pipe[i]),
            .u_reg (u_pipe[i+1]),
            .v_reg (v_pipe[i+1]),
            .z_reg (z_pipe[i+1])
        );
    end

    svr_gain #(
        .W          (W),
        .COORD_BITS (C)
    ) u_gain_u (
        .clk     (clk),
        .en      (advance),
        .w_in    (u_pipe[ITERATIONS]),
        .res_reg (ru),
        .sat_reg (sat_u)
    );

    svr_gain #(
        .W          (W),
        .COORD_BITS (C)
    ) u_gain_v (
        .clk     (clk),
        .en      (advance),
        .w_in    (v_pipe[ITERATIONS]),
        .res_reg (rv),
        .sat_reg (sat_v)
    );

    // place the rotated pair back on its axes
    always_comb
    begin
        mode_last = svr_mode_t'(side_reg[DEPTH-1][SW-1 -: 2]);
        xo        = side_reg[DEPTH-1][3*C-1 -: C];
        yo        = side_reg[DEPTH-1][2*C-1 -: C];
        zo        = side_reg[DEPTH-1][C-1:0];
        xr        = xo;
        yr        = yo;
        zr        = zo;
        sr        = sat_u | sat_v;
        unique case (mode_last)
            MODE_X:
            begin
                yr = ru;
                zr = rv;
            end
            MODE_Y:
            begin
                zr = ru;
                xr = rv;
            end
            MODE_Z:
            begin
                xr = ru;
                yr = rv;
            end
            default:
            begin
                sr = 1'b0;
            end
        endcase
        res_last = {sr, xr, yr, zr};
    end

    // output buffer takes one item while the sink stalls
    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg)
        begin
            if (out_ready)
            begin
                skid_full_next = 1'b0;
            end
        end
        else if (valid_reg[DEPTH-1] && !out_ready)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_reg <= res_last;
        end
    end

    assign res_out   = skid_full_reg ? skid_reg : res_last;
    assign out_valid = skid_full_reg | valid_reg[DEPTH-1];
    assign saturated = res_out[RES_W-1];
    assign x_out     = res_out[3*C-1 -: C];
    assign y_out     = res_out[2*C-1 -: C];
    assign z_out     = res_out[C-1:0];

    // input stalls only after an item was refused at the output
    `SVR_ASSERT(a_stall_cause, $fell(in_ready) |-> $past(out_valid && !out_ready))
    // the buffer drains only into a ready sink
    `SVR_ASSERT(a_drain_cause, $rose(in_ready) |-> $past(out_ready))
    // a new result at the output came from the stage before it
    `SVR_ASSERT(a_valid_flow, ($rose(out_valid) && !skid_full_reg) |-> $past(valid_reg[DEPTH-2]))
    // a pass-through item is never flagged
    `SVR_ASSERT_NEXT(a_none_unsat,
        valid_reg[DEPTH-2] && advance && (side_reg[DEPTH-2][SW-1 -: 2] == MODE_NONE),
        !res_last[RES_W-1])

endmodule
